// ===== hw/rtl/bsm_pkg.sv =====
// Package for the bank switch mapper: command, target and register codes,
// bus decode keys and default address widths.
// No dependencies.
`timescale 1ns / 1ps

package bsm_pkg;

   localparam int PRG_ADDR_BITS_DEFAULT = 19;
   localparam int CHR_ADDR_BITS_DEFAULT = 18;

   // Commands carried in the request tuser field.
   localparam logic [2:0] CMD_CPU_WRITE = 3'd0;
   localparam logic [2:0] CMD_CPU_READ  = 3'd1;
   localparam logic [2:0] CMD_PPU_FETCH = 3'd2;
   localparam logic [2:0] CMD_A12_RISE  = 3'd3;
   localparam logic [2:0] CMD_STEP_TICK = 3'd4;

   // Result targets carried in the response tuser field.
   localparam logic [2:0] TGT_NONE      = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
   localparam logic [2:0] TGT_PRG_RAM   = 3'd2;
   localparam logic [2:0] TGT_CHR       = 3'd3;
   localparam logic [2:0] TGT_RAM_BLOCK = 3'd4;

   // Configuration register indexes (byte address is four times the index).
   localparam logic [2:0] CSR_SIMPLE_VARIANT  = 3'd0;
   localparam logic [2:0] CSR_IRQ_RELOAD_ONLY = 3'd1;
   localparam logic [2:0] CSR_PRG_BANK_COUNT  = 3'd2;
   localparam logic [2:0] CSR_FOUR_SCREEN     = 3'd3;
   localparam logic [2:0] CSR_SRAM_FULL_SIZE  = 3'd4;

   // CPU register decode: address bits 15:13 and 0 select the register.
   localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
   localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
   localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
   localparam logic [15:0] REG_MIRROR      = 16'hA000;
   localparam logic [15:0] REG_RAM_PROTECT = 16'hA001;
   localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
   localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
   localparam logic [15:0] REG_IRQ_ACK     = 16'hE000;
   localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;
   localparam logic [15:0] SIMPLE_TOP_ADDR = 16'h9FFF;

   localparam logic [15:0] RAM_BASE_ADDR   = 16'h6000;
   localparam logic [15:0] ROM_BASE_ADDR   = 16'h8000;
   localparam logic [15:0] CHR_LIMIT_ADDR  = 16'h2000;

   localparam logic [7:0]  SIMPLE_BANK_MASK = 8'h3F;
   localparam logic [6:0]  PRG_COUNT_RESET  = 7'd64;

endpackage

// ===== hw/rtl/bank_switch_mapper_with_scanline_irq.sv =====
// Bank switch mapper with scanline IRQ counter: translates CPU and PPU
// transactions into physical PRG ROM, PRG RAM and CHR addresses.
// The response is registered and is valid in the cycle after request acceptance.
// Throughput: one transaction per clock; the single response register
// accepts a new request whenever it is empty or being drained.
// Reset (synchronous, active high) restores all mapper and CSR state.
`timescale 1ns / 1ps

module bank_switch_mapper_with_scanline_irq
   import bsm_pkg::*;
#(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT,
   parameter int CHR_ADDR_BITS = CHR_ADDR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // addr[15:0], data[23:16]
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // phys_addr[18:0], mirror_horizontal[19],
                                    // irq_line[20], zero[23:21]
   output logic [2:0]  rsp_tuser,   // target[2:0]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [19:0] PRG_MASK = 20'((64'd1 << PRG_ADDR_BITS) - 64'd1);
   localparam logic [17:0] CHR_MASK = 18'((64'd1 << CHR_ADDR_BITS) - 64'd1);

   // Configuration registers.
   logic       simple_variant_ff;
   logic       irq_reload_only_ff;
   logic [6:0] prg_bank_count_ff;
   logic       four_screen_ff;
   logic       sram_full_size_ff;

   // Mapper state.
   logic [7:0] bank_regs_ff [8];
   logic [7:0] bank_regs_in [8];
   logic [2:0] bank_select_ff, bank_select_in;
   logic       prg_swap_ff, prg_swap_in;
   logic       chr_invert_ff, chr_invert_in;
   logic       ram_write_on_ff, ram_write_on_in;
   logic       ram_read_on_ff, ram_read_on_in;
   logic       mirror_ff, mirror_in;
   logic [7:0] irq_count_ff, irq_count_in;
   logic [7:0] irq_latch_ff, irq_latch_in;
   logic       irq_enable_ff, irq_enable_in;
   logic       irq_reload_ff, irq_reload_in;
   logic       irq_pending_ff, irq_pending_in;
   logic       irq_ack_ff, irq_ack_in;
   logic       irq_level_ff, irq_level_in;

   // Response register.
   logic        rsp_valid_ff;
   logic [18:0] rsp_phys_ff, rsp_phys_in;
   logic [2:0]  rsp_target_ff, rsp_target_in;

   logic        req_accept;
   logic        csr_write;
   logic [15:0] req_addr;
   logic [7:0]  req_data;
   logic [2:0]  req_cmd;

   assign req_addr   = req_tdata[15:0];
   assign req_data   = req_tdata[23:16];
   assign req_cmd    = req_tuser;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[4:2])
         CSR_SIMPLE_VARIANT:  csr_prdata = {31'd0, simple_variant_ff};
         CSR_IRQ_RELOAD_ONLY: csr_prdata = {31'd0, irq_reload_only_ff};
         CSR_PRG_BANK_COUNT:  csr_prdata = {25'd0, prg_bank_count_ff};
         CSR_FOUR_SCREEN:     csr_prdata = {31'd0, four_screen_ff};
         CSR_SRAM_FULL_SIZE:  csr_prdata = {31'd0, sram_full_size_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         simple_variant_ff  <= 1'b0;
         irq_reload_only_ff <= 1'b0;
         prg_bank_count_ff  <= PRG_COUNT_RESET;
         four_screen_ff     <= 1'b0;
         sram_full_size_ff  <= 1'b1;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            CSR_SIMPLE_VARIANT:  simple_variant_ff  <= csr_pwdata[0];
            CSR_IRQ_RELOAD_ONLY: irq_reload_only_ff <= csr_pwdata[0];
            CSR_PRG_BANK_COUNT:  prg_bank_count_ff  <= csr_pwdata[6:0];
            CSR_FOUR_SCREEN:     four_screen_ff     <= csr_pwdata[0];
            CSR_SRAM_FULL_SIZE:  sram_full_size_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Next state and response for one transaction.
   always_comb begin
      logic [6:0]  last_bank;
      logic [6:0]  second_bank;
      logic [6:0]  prg_bank;
      logic [19:0] prg_full;
      logic [12:0] chr_addr;
      logic [2:0]  chr_index;
      logic [7:0]  chr_bank;
      logic [17:0] chr_full;
      logic        in_ram;
      logic        in_rom;
      logic        raise;

      for (int i = 0; i < 8; i++) begin
         bank_regs_in[i] = bank_regs_ff[i];
      end
      bank_select_in  = bank_select_ff;
      prg_swap_in     = prg_swap_ff;
      chr_invert_in   = chr_invert_ff;
      ram_write_on_in = ram_write_on_ff;
      ram_read_on_in  = ram_read_on_ff;
      mirror_in       = mirror_ff;
      irq_count_in    = irq_count_ff;
      irq_latch_in    = irq_latch_ff;
      irq_enable_in   = irq_enable_ff;
      irq_reload_in   = irq_reload_ff;
      irq_pending_in  = irq_pending_ff;
      irq_ack_in      = irq_ack_ff;
      irq_level_in    = irq_level_ff;
      rsp_phys_in     = 19'd0;
      rsp_target_in   = TGT_NONE;
      raise           = 1'b1;

      in_ram = (req_addr >= RAM_BASE_ADDR) && (req_addr < ROM_BASE_ADDR);
      in_rom = (req_addr >= ROM_BASE_ADDR);

      // PRG ROM window: the last two banks are fixed, the swap mode trades
      // the first and third windows.
      last_bank   = prg_bank_count_ff - 7'd1;
      second_bank = last_bank - 7'd1;
      case (req_addr[14:13])
         2'd0:    prg_bank = prg_swap_ff ? second_bank : bank_regs_ff[6][6:0];
         2'd1:    prg_bank = bank_regs_ff[7][6:0];
         2'd2:    prg_bank = prg_swap_ff ? bank_regs_ff[6][6:0] : second_bank;
         default: prg_bank = last_bank;
      endcase
      prg_full = {prg_bank, req_addr[12:0]} & PRG_MASK;

      // CHR windows: two 2K banks in one half, four 1K banks in the other.
      chr_addr = req_addr[12:0] ^ {chr_invert_ff, 12'd0};
      if (!chr_addr[12]) begin
         chr_index = {2'b00, chr_addr[11]};
      end else begin
         chr_index = 3'd2 + {1'b0, chr_addr[11:10]};
      end
      chr_bank = bank_regs_ff[chr_index];
      if (!chr_addr[12]) begin
         chr_full = {chr_bank[7:1], chr_addr[10:0]};
      end else begin
         chr_full = {chr_bank, chr_addr[9:0]};
      end
      chr_full = chr_full & CHR_MASK;

      case (req_cmd)
         CMD_CPU_WRITE: begin
            if (in_ram) begin
               if (ram_write_on_ff) begin
                  rsp_target_in = TGT_PRG_RAM;
                  rsp_phys_in   = {6'd0, req_addr[12:0]};
               end
            end else if (in_rom && !(simple_variant_ff && req_addr > SIMPLE_TOP_ADDR)) begin
               case (req_addr & REG_DECODE_MASK)
                  REG_BANK_SELECT: begin
                     bank_select_in = req_data[2:0];
                     if (!simple_variant_ff) begin
                        prg_swap_in   = req_data[6];
                        chr_invert_in = req_data[7];
                     end
                  end
                  REG_BANK_DATA: begin
                     bank_regs_in[bank_select_ff] = simple_variant_ff ?
                        (req_data & SIMPLE_BANK_MASK) : req_data;
                  end
                  REG_MIRROR: begin
                     if (!four_screen_ff) begin
                        mirror_in = req_data[0];
                     end
                  end
                  REG_RAM_PROTECT: begin
                     if (sram_full_size_ff) begin
                        ram_write_on_in = !req_data[6];
                        ram_read_on_in  = req_data[7];
                     end
                  end
                  REG_IRQ_LATCH:  irq_latch_in  = req_data;
                  REG_IRQ_RELOAD: irq_reload_in = 1'b1;
                  REG_IRQ_ACK: begin
                     irq_ack_in    = 1'b1;
                     irq_enable_in = 1'b0;
                  end
                  REG_IRQ_ENABLE: irq_enable_in = 1'b1;
                  default: ;
               endcase
            end
         end
         CMD_CPU_READ: begin
            if (in_ram) begin
               if (ram_read_on_ff) begin
                  rsp_target_in = TGT_PRG_RAM;
                  rsp_phys_in   = {6'd0, req_addr[12:0]};
               end else begin
                  rsp_target_in = TGT_RAM_BLOCK;
               end
            end else if (in_rom) begin
               rsp_target_in = TGT_PRG_ROM;
               rsp_phys_in   = prg_full[18:0];
            end
         end
         CMD_PPU_FETCH: begin
            if (req_addr < CHR_LIMIT_ADDR) begin
               rsp_target_in = TGT_CHR;
               rsp_phys_in   = {1'b0, chr_full};
            end
         end
         CMD_A12_RISE: begin
            irq_pending_in = 1'b1;
         end
         CMD_STEP_TICK: begin
            // An acknowledge drops the line first; a pending A12 edge then
            // clocks the counter and may raise it again.
            if (irq_ack_ff) begin
               irq_level_in = 1'b0;
               irq_ack_in   = 1'b0;
            end
            if (irq_pending_ff) begin
               if (irq_count_ff == 8'd0 || irq_reload_ff) begin
                  if (irq_reload_only_ff) begin
                     raise = irq_reload_ff;
                  end
                  irq_reload_in = 1'b0;
                  irq_count_in  = irq_latch_ff;
               end else begin
                  irq_count_in = irq_count_ff - 8'd1;
               end
               if (raise && irq_enable_ff && irq_count_in == 8'd0) begin
                  irq_level_in = 1'b1;
               end
               irq_pending_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            bank_regs_ff[i] <= (i == 7) ? 8'd1 : 8'd0;
         end
         bank_select_ff  <= 3'd0;
         prg_swap_ff     <= 1'b0;
         chr_invert_ff   <= 1'b0;
         ram_write_on_ff <= 1'b1;
         ram_read_on_ff  <= 1'b1;
         mirror_ff       <= 1'b0;
         irq_count_ff    <= 8'd0;
         irq_latch_ff    <= 8'd0;
         irq_enable_ff   <= 1'b0;
         irq_reload_ff   <= 1'b0;
         irq_pending_ff  <= 1'b0;
         irq_ack_ff      <= 1'b0;
         irq_level_ff    <= 1'b0;
      end else if (req_accept) begin
         for (int i = 0; i < 8; i++) begin
            bank_regs_ff[i] <= bank_regs_in[i];
         end
         bank_select_ff  <= bank_select_in;
         prg_swap_ff     <= prg_swap_in;
         chr_invert_ff   <= chr_invert_in;
         ram_write_on_ff <= ram_write_on_in;
         ram_read_on_ff  <= ram_read_on_in;
         mirror_ff       <= mirror_in;
         irq_count_ff    <= irq_count_in;
         irq_latch_ff    <= irq_latch_in;
         irq_enable_ff   <= irq_enable_in;
         irq_reload_ff   <= irq_reload_in;
         irq_pending_ff  <= irq_pending_in;
         irq_ack_ff      <= irq_ack_in;
         irq_level_ff    <= irq_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_phys_ff   <= rsp_phys_in;
         rsp_target_ff <= rsp_target_in;
      end
   end

   // Mirroring and IRQ level are taken from state, which only changes on
   // an accepted transaction, so they match the held response.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, irq_level_ff, mirror_ff, rsp_phys_ff};
   assign rsp_tuser  = rsp_target_ff;

endmodule
